// File: hw/rtl/tlsa_pkg.sv
// shared types, constants and map helpers for the slot index allocator
package tlsa_pkg;

  localparam int BASE_TABLE_SLOTS = 80;
  localparam int EXT_SLOTS        = 1024;
  localparam int WORD_BITS        = 32;
  localparam int BIT_W            = $clog2(WORD_BITS);
  localparam int BASE_WORDS       = (BASE_TABLE_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int EXT_WORDS        = (EXT_SLOTS + WORD_BITS - 1) / WORD_BITS;
  localparam int TOTAL_WORDS      = BASE_WORDS + EXT_WORDS;
  localparam int WADDR_W          = $clog2(TOTAL_WORDS);
  localparam int BASE_USABLE      = BASE_TABLE_SLOTS - 1;
  localparam int TOTAL_USABLE     = BASE_USABLE + EXT_SLOTS;
  localparam int RSV_WORD         = (BASE_TABLE_SLOTS - 1) / WORD_BITS;
  localparam int RSV_BIT          = (BASE_TABLE_SLOTS - 1) % WORD_BITS;
  localparam int IDX_W            = 11;
  localparam int STAT_W           = 2;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STAT_W-1:0] ST_INVALID   = 2'd2;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  typedef struct packed {
    logic             op;
    logic [IDX_W-1:0] slot_index;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  granted_index;
    logic [STAT_W-1:0] status;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic load;    // latch accepted item
    logic reject;  // free out of range, answer at once
    logic adv;     // step to next word and read it
    logic finish;  // resolve current word and answer
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic in_free;
    logic in_range;
    logic op_free;
    logic found;
    logic last_word;
  } dp_sts_t;

  // contents of a map word after reset
  function automatic logic [WORD_BITS-1:0] reset_word(input logic [WADDR_W-1:0] w);
    logic [WORD_BITS-1:0] v;
    v = '0;
    if (int'(w) == RSV_WORD) v[RSV_BIT] = 1'b1;
    return v;
  endfunction

  // bits of a word that never get handed out
  function automatic logic [WORD_BITS-1:0] scan_mask(input logic [WADDR_W-1:0] w);
    logic [WORD_BITS-1:0] m;
    int pos;
    m = '0;
    pos = 0;
    for (int b = 0; b < WORD_BITS; b++) begin
      if (int'(w) < BASE_WORDS) begin
        pos  = int'(w) * WORD_BITS + b;
        m[b] = (pos >= BASE_USABLE);
      end else begin
        pos  = (int'(w) - BASE_WORDS) * WORD_BITS + b;
        m[b] = (pos >= EXT_SLOTS);
      end
    end
    return m;
  endfunction

  // slot index of bit 0 of a word
  function automatic logic [IDX_W-1:0] word_base_index(input logic [WADDR_W-1:0] w);
    int v;
    if (int'(w) < BASE_WORDS) v = int'(w) * WORD_BITS;
    else                      v = BASE_USABLE + (int'(w) - BASE_WORDS) * WORD_BITS;
    return IDX_W'(v);
  endfunction

endpackage

// File: hw/rtl/tlsa_ram.sv
// generic single-port-write ram with registered read
module tlsa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: hw/rtl/tlsa_datapath.sv
// bitmap storage, word scan, free check and result register
module tlsa_datapath import tlsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_strobe,
  output out_item_t out_data
);

  logic                   op_r;
  logic [WADDR_W-1:0]     ptr_r;
  logic [BIT_W-1:0]       bit_r;
  logic [TOTAL_WORDS-1:0] vld_r;
  logic                   rvld_r;
  logic                   strobe_r;
  out_item_t              out_r;

  logic [WADDR_W-1:0]     raddr;
  logic [WORD_BITS-1:0]   rdata;
  logic [WORD_BITS-1:0]   word_eff;
  logic [WORD_BITS-1:0]   cur;
  logic [BIT_W-1:0]       fb;
  logic                   found;
  logic                   bit_set;
  logic                   we;
  logic [WORD_BITS-1:0]   wdata;
  logic [IDX_W-1:0]       idx;
  logic [IDX_W-1:0]       ext_k;
  logic [IDX_W-1:0]       ext_w;

  assign raddr = cmd.adv ? ptr_r + WADDR_W'(1) : ptr_r;

  tlsa_ram #(.WIDTH(WORD_BITS), .DEPTH(TOTAL_WORDS)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (ptr_r),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // unwritten words read as their reset value
  assign word_eff = rvld_r ? rdata : reset_word(ptr_r);
  assign cur      = word_eff | scan_mask(ptr_r);
  assign found    = (cur != '1);
  assign bit_set  = word_eff[bit_r];

  always_comb begin
    fb = '0;
    for (int b = WORD_BITS - 1; b >= 0; b--) begin
      if (!cur[b]) fb = BIT_W'(b);
    end
  end

  always_comb begin
    we    = 1'b0;
    wdata = word_eff;
    if (cmd.finish) begin
      if (op_r == OP_ALLOC) begin
        we        = found;
        wdata[fb] = 1'b1;
      end else begin
        we           = bit_set;
        wdata[bit_r] = 1'b0;
      end
    end
  end

  // free target word and bit
  assign idx   = in_data.slot_index;
  assign ext_k = idx - IDX_W'(BASE_USABLE);
  assign ext_w = IDX_W'(BASE_WORDS) + (ext_k >> BIT_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= cmd.finish | cmd.reject;
      if (we) vld_r[ptr_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    rvld_r <= vld_r[raddr];
    if (cmd.load) begin
      op_r <= in_data.op;
      if (in_data.op == OP_ALLOC) begin
        ptr_r <= '0;
        bit_r <= '0;
      end else if (idx < IDX_W'(BASE_USABLE)) begin
        ptr_r <= idx[BIT_W +: WADDR_W];
        bit_r <= idx[BIT_W-1:0];
      end else begin
        ptr_r <= ext_w[WADDR_W-1:0];
        bit_r <= ext_k[BIT_W-1:0];
      end
    end else if (cmd.adv) begin
      ptr_r <= raddr;
    end
    if (cmd.reject) begin
      out_r.granted_index <= '0;
      out_r.status        <= ST_INVALID;
    end else if (cmd.finish) begin
      if (op_r == OP_ALLOC) begin
        out_r.granted_index <= found ? word_base_index(ptr_r) + IDX_W'(fb) : '0;
        out_r.status        <= found ? ST_OK : ST_EXHAUSTED;
      end else begin
        out_r.granted_index <= '0;
        out_r.status        <= bit_set ? ST_OK : ST_INVALID;
      end
    end
  end

  assign sts.in_free   = (in_data.op == OP_FREE);
  assign sts.in_range  = (idx < IDX_W'(TOTAL_USABLE));
  assign sts.op_free   = (op_r == OP_FREE);
  assign sts.found     = found;
  assign sts.last_word = (ptr_r == WADDR_W'(TOTAL_WORDS - 1));

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

// File: hw/rtl/tlsa_ctrl.sv
// sequencer for allocate scan and free check
module tlsa_ctrl import tlsa_pkg::*; (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  input  dp_sts_t sts,
  output logic    busy,
  output dp_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_CHK  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          if (sts.in_free && !sts.in_range) cmd.reject = 1'b1;
          else                              state_nxt  = S_RD;
        end
      end
      S_RD: begin
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.op_free || sts.found || sts.last_word) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end else begin
          cmd.adv = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

// File: hw/rtl/two_level_slot_index_allocator_top.sv
// top level of the two-level lowest-free slot index allocator
// free: busy through the read and check states, result strobe registered from the check
// free out of range: busy stays low, result strobe in the cycle after the accept
// allocate: busy through the read state and a check of each map word from 0 to n,
//   the grant's word or else the last (0..34); one-word-per-cycle ram scan
// reset: synchronous, active low; per-word written flags are cleared so every
//   word reads as its reset value at once, no clearing pass; results cannot stall
module two_level_slot_index_allocator_top import tlsa_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  // command side: transfer when start is high and busy is low
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_data,
  // result side: one-cycle strobe, always taken
  output logic      out_strobe,
  output out_item_t out_data
);

  // command and status between sequencer and datapath
  dp_cmd_t cmd;
  dp_sts_t sts;

  // sequencer: idle, read a word, check the word (scan stays here per word)
  tlsa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  // datapath: 35-word map ram (3 base words then 32 extended words),
  // lowest-zero search, free bit check and result register
  tlsa_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_data    (in_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // a grant index only comes with an ok status
  a_zero_on_fail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_data.status != ST_OK) |-> (out_data.granted_index == '0))
    else $error("nonzero index on failed transfer");

  // granted index stays inside the usable range
  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_data.granted_index < IDX_W'(TOTAL_USABLE)))
    else $error("granted index out of range");

  // finishing a busy item always yields its result right away
  a_result_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ($fell(busy) && $past(rst_n)) |-> out_strobe)
    else $error("busy dropped without a result");

  // no result is shown while an item is in flight
  a_no_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !out_strobe)
    else $error("result strobe while busy");

endmodule

// File: test/tlsa_tb_pkg.sv
// scoreboard for the slot index allocator: bitmap mirror and queue of awaited replies
package tlsa_tb_pkg;
  import tlsa_pkg::*;

  class slot_ledger;
    // usable bits only; the reserved base bit is never handed out or released
    logic [BASE_USABLE-1:0] base_used;
    logic [EXT_SLOTS-1:0]   ext_used;
    int                     errors;
    out_item_t              awaited_replies[$];

    function new();
      base_used  = '0;
      ext_used   = '0;
      errors     = 0;
    endfunction

    function bit is_used(int idx);
      if (idx < BASE_USABLE) return base_used[idx];
      if (idx < TOTAL_USABLE) return ext_used[idx - BASE_USABLE];
      return 1'b0;
    endfunction

    function int pending();
      return awaited_replies.size();
    endfunction

    // first allocated index at or after a start point, wrapping; start point if none
    function int pick_used(int from);
      int p;
      for (int n = 0; n < TOTAL_USABLE; n++) begin
        p = (from + n) % TOTAL_USABLE;
        if (is_used(p)) return p;
      end
      return from;
    endfunction

    // lowest-free grant or release, applied to the mirrored maps
    function out_item_t grant_or_release(in_item_t item);
      out_item_t r;
      int        idx;
      r.granted_index = '0;
      r.status        = ST_EXHAUSTED;
      idx             = int'(item.slot_index);
      if (item.op == OP_ALLOC) begin
        for (int k = 0; k < BASE_USABLE && r.status != ST_OK; k++) begin
          if (!base_used[k]) begin
            base_used[k]    = 1'b1;
            r.granted_index = IDX_W'(k);
            r.status        = ST_OK;
          end
        end
        for (int k = 0; k < EXT_SLOTS && r.status != ST_OK; k++) begin
          if (!ext_used[k]) begin
            ext_used[k]     = 1'b1;
            r.granted_index = IDX_W'(BASE_USABLE + k);
            r.status        = ST_OK;
          end
        end
      end else begin
        r.status = ST_INVALID;
        if (idx < BASE_USABLE) begin
          if (base_used[idx]) begin
            base_used[idx] = 1'b0;
            r.status       = ST_OK;
          end
        end else if (idx < TOTAL_USABLE) begin
          if (ext_used[idx - BASE_USABLE]) begin
            ext_used[idx - BASE_USABLE] = 1'b0;
            r.status                    = ST_OK;
          end
        end
      end
      return r;
    endfunction

    function void book_request(in_item_t item);
      awaited_replies.push_back(grant_or_release(item));
    endfunction

    function void match_result(out_item_t got);
      out_item_t want;
      if (awaited_replies.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, index %0d status %0d", $time,
                 got.granted_index, got.status);
        return;
      end
      want = awaited_replies.pop_front();
      if (got.granted_index !== want.granted_index) begin
        errors++;
        $display("%0t: granted_index mismatch, expected %0d actual %0d", $time,
                 want.granted_index, got.granted_index);
      end
      if (got.status !== want.status) begin
        errors++;
        $display("%0t: status mismatch, expected %0d actual %0d", $time,
                 want.status, got.status);
      end
    endfunction

    function void flush_leftovers();
      out_item_t want;
      while (awaited_replies.size() != 0) begin
        want = awaited_replies.pop_front();
        errors++;
        $display("%0t: missing result, expected index %0d status %0d", $time,
                 want.granted_index, want.status);
      end
    endfunction
  endclass

endpackage

// File: test/tb_two_level_slot_index_allocator_top.sv
// testbench for the two-level slot index allocator: directed and random traffic
module tb_two_level_slot_index_allocator_top;
  import tlsa_pkg::*;
  import tlsa_tb_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_data;
  logic      out_strobe;
  out_item_t out_data;

  // chance in percent that the sender idles before each item, drawn again to extend the gap
  int         idle_pct;
  slot_ledger ledger;

  two_level_slot_index_allocator_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_data    (in_data),
    .out_strobe (out_strobe),
    .out_data   (out_data)
  );

  // 4-unit clock
  initial clk = 1'b0;
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side: the strobe lasts one cycle and cannot be held off,
  // so every strobed result is checked at the edge that ends its cycle
  always @(posedge clk) begin
    if (rst_n && out_strobe === 1'b1) ledger.match_result(out_data);
  end

  // one command transfer: optional idle gap, then start held until busy is low
  // at a rising edge; the ledger is updated by the driver itself at that edge
  // so the next item can be chosen from the current map state
  task automatic send_item(input logic op, input logic [IDX_W-1:0] idx);
    in_item_t item;
    int       gap;
    gap = 0;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct && gap < 60) gap++;
    if (gap > 0) begin
      @(negedge clk);
      start <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    item.op         = op;
    item.slot_index = idx;
    @(negedge clk);
    start   <= 1'b1;
    in_data <= item;
    do @(posedge clk); while (busy);
    ledger.book_request(item);
  endtask

  // sender goes quiet until every awaited reply has come back
  task automatic pause_until_drained();
    @(negedge clk);
    start <= 1'b0;
    while (ledger.pending() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // one random item; frees mostly hit allocated slots so the map really moves,
  // the rest probe unallocated, out-of-range and boundary indices
  task automatic random_item(input int alloc_pct);
    logic [IDX_W-1:0] idx;
    int               r;
    idx = IDX_W'($urandom_range(2047));
    if ($urandom_range(99) < alloc_pct) begin
      send_item(OP_ALLOC, idx);
    end else begin
      r = $urandom_range(99);
      if (r < 70) begin
        idx = IDX_W'(ledger.pick_used($urandom_range(TOTAL_USABLE - 1)));
      end else if (r < 85) begin
        idx = IDX_W'($urandom_range(TOTAL_USABLE - 1));
      end else if (r < 95) begin
        idx = IDX_W'($urandom_range(2047, TOTAL_USABLE));
      end else begin
        case ($urandom_range(5))
          0: idx = '0;
          1: idx = IDX_W'(BASE_USABLE - 1);
          2: idx = IDX_W'(BASE_USABLE);
          3: idx = IDX_W'(TOTAL_USABLE - 1);
          4: idx = IDX_W'(TOTAL_USABLE);
          default: idx = '1;
        endcase
      end
      send_item(OP_FREE, idx);
    end
  endtask

  task automatic random_run(input int count, input int alloc_pct);
    repeat (count) random_item(alloc_pct);
  endtask

  initial begin
    int w;
    ledger   = new();
    rst_n    = 1'b0;
    start    = 1'b0;
    in_data  = '0;
    idle_pct = 0;
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // directed: first grants, slot_index ignored on allocate
    send_item(OP_ALLOC, '0);
    send_item(OP_ALLOC, '1);
    send_item(OP_ALLOC, IDX_W'($urandom_range(2047)));
    // release and double release, then the hole is refilled lowest-first
    send_item(OP_FREE, IDX_W'(1));
    send_item(OP_FREE, IDX_W'(1));
    send_item(OP_ALLOC, '0);
    send_item(OP_FREE, '0);
    send_item(OP_FREE, '0);
    // reserved base bit: its index belongs to the extended map, not yet used
    send_item(OP_FREE, IDX_W'(BASE_USABLE));
    // unallocated top of base, top of extended map, just past the range, all ones
    send_item(OP_FREE, IDX_W'(BASE_USABLE - 1));
    send_item(OP_FREE, IDX_W'(TOTAL_USABLE - 1));
    send_item(OP_FREE, IDX_W'(TOTAL_USABLE));
    send_item(OP_FREE, '1);
    send_item(OP_FREE, IDX_W'(1024));
    send_item(OP_ALLOC, '1);
    send_item(OP_FREE, IDX_W'(2));
    send_item(OP_ALLOC, '0);

    // random, back to back, leaning toward allocate to push into the extended map
    random_run(100, 65);
    // sender mostly idle
    idle_pct = 85;
    random_run(100, 50);
    // sender pauses until the block has answered everything
    pause_until_drained();
    // light idling
    idle_pct = 9;
    random_run(100, 55);
    // stretch with no idling
    idle_pct = 0;
    random_run(100, 45);

    // all stimulus taken: wait for outstanding replies, then a short tail
    @(negedge clk);
    start <= 1'b0;
    for (w = 0; w < 5000 && ledger.pending() != 0; w++) @(posedge clk);
    repeat (40) @(posedge clk);
    ledger.flush_leftovers();
    if (ledger.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // watchdog well beyond the slowest legal run
  initial begin
    #4000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
